### hdl/svsc_pkg.sv
// ----------------------------------------------------------------------------
// svsc_pkg: shared types and constants for the stream statistics block
// Payload structs, accumulator snapshot, shared ALU request and response, widths and step counts.
// ----------------------------------------------------------------------------
package svsc_pkg;

    localparam int MAX_SAMPLES = 1024;

    localparam int SAMPLE_W = 16;
    localparam int SUM_W    = 26;
    localparam int SQ_W     = 41;
    localparam int CNT_W    = 11;
    localparam int NN_W     = 21;
    localparam int VAR_W    = 31;
    localparam int SD_W     = 16;
    localparam int CV_W     = 32;
    localparam int ALU_W    = 52;

    localparam int STEP_W     = 6;
    localparam int MUL_STEPS  = 26;
    localparam int DIV_STEPS  = 52;
    localparam int SQRT_STEPS = 16;

    localparam logic [CNT_W-1:0]  MAX_CNT = CNT_W'(MAX_SAMPLES);
    localparam logic [ALU_W-1:0]  SQRT_BIT0 = ALU_W'(1) << (2 * SQRT_STEPS - 2);
    localparam logic [CV_W-1:0]   CV_MAX = {1'b0, {(CV_W-1){1'b1}}};

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } t_in;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] mean;
        logic [VAR_W-1:0]           variance;
        logic [SD_W-1:0]            std_dev;
        logic signed [CV_W-1:0]     coeff_var;
        logic                       cv_undefined;
        logic [CNT_W-1:0]           sample_count;
        logic                       too_many;
    } t_out;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic [SQ_W-1:0]         sq;
        logic [CNT_W-1:0]        n;
        logic                    ovf;
    } t_snap;

    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic             sub;
    } t_alu_req;

    typedef struct packed {
        logic [ALU_W-1:0] res;
        logic             carry;
    } t_alu_rsp;

endpackage

### hdl/svsc_alu.sv
// ----------------------------------------------------------------------------
// svsc_alu: shared add/subtract unit
// One wide adder used by the multiply, divide and square root steps and the numerator subtract.
// ----------------------------------------------------------------------------
module svsc_alu (
    input  svsc_pkg::t_alu_req i_req,
    output svsc_pkg::t_alu_rsp o_rsp
);

    logic [svsc_pkg::ALU_W:0] w_sum;

    // carry out on subtract means a >= b
    assign w_sum = {1'b0, i_req.a}
                 + {1'b0, (i_req.sub ? ~i_req.b : i_req.b)}
                 + {{svsc_pkg::ALU_W{1'b0}}, i_req.sub};

    assign o_rsp.res   = w_sum[svsc_pkg::ALU_W-1:0];
    assign o_rsp.carry = w_sum[svsc_pkg::ALU_W];

endmodule

### hdl/svsc_acc.sv
// ----------------------------------------------------------------------------
// svsc_acc: running sum, sum of squares and sample count
// Takes one sample per cycle while i_accept is high; clears after the last sample of a vector.
// ----------------------------------------------------------------------------
module svsc_acc (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  svsc_pkg::t_in    i_item,
    output svsc_pkg::t_snap  o_snap
);

    logic signed [svsc_pkg::SUM_W-1:0] r_sum;
    logic [svsc_pkg::SQ_W-1:0]         r_sq;
    logic [svsc_pkg::CNT_W-1:0]        r_n;
    logic                              r_ovf;

    logic signed [2*svsc_pkg::SAMPLE_W-1:0] w_prod;
    logic                                   w_room;

    assign w_prod = i_item.sample * i_item.sample;
    assign w_room = (r_n < svsc_pkg::MAX_CNT);

    // snapshot includes the sample being accepted, unless the count is already at MAX_CNT (then ovf is set)
    always_comb begin
        o_snap.sum = r_sum;
        o_snap.sq  = r_sq;
        o_snap.n   = r_n;
        o_snap.ovf = r_ovf | ~w_room;
        if (w_room) begin
            o_snap.sum = r_sum + svsc_pkg::SUM_W'(i_item.sample);
            o_snap.sq  = r_sq + svsc_pkg::SQ_W'(w_prod[2*svsc_pkg::SAMPLE_W-2:0]);
            o_snap.n   = r_n + svsc_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_sq  <= '0;
            r_n   <= '0;
            r_ovf <= 1'b0;
        end else if (i_accept) begin
            if (i_item.last) begin
                r_sum <= '0;
                r_sq  <= '0;
                r_n   <= '0;
                r_ovf <= 1'b0;
            end else begin
                r_sum <= o_snap.sum;
                r_sq  <= o_snap.sq;
                r_n   <= o_snap.n;
                r_ovf <= o_snap.ovf;
            end
        end
    end

endmodule

### hdl/svsc_seq.sv
// ----------------------------------------------------------------------------
// svsc_seq: end-of-vector sequencer
// Drives the shared ALU through shift-add multiplies, restoring divides and
// a bitwise square root, then holds the result in an output register.
// ----------------------------------------------------------------------------
module svsc_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  svsc_pkg::t_snap    i_snap,
    output logic               o_idle,
    output svsc_pkg::t_alu_req o_alu_req,
    input  svsc_pkg::t_alu_rsp i_alu_rsp,
    output logic               o_valid,
    input  logic               i_ready,
    output svsc_pkg::t_out     o_data
);

    typedef enum logic [9:0] {
        ST_IDLE     = 10'b00_0000_0001,
        ST_MUL_NN   = 10'b00_0000_0010,
        ST_MUL_NQ   = 10'b00_0000_0100,
        ST_MUL_S2   = 10'b00_0000_1000,
        ST_NUM      = 10'b00_0001_0000,
        ST_DIV_VAR  = 10'b00_0010_0000,
        ST_SQRT     = 10'b00_0100_0000,
        ST_DIV_MEAN = 10'b00_1000_0000,
        ST_DIV_CV   = 10'b01_0000_0000,
        ST_DONE     = 10'b10_0000_0000
    } t_state;

    localparam int AW = svsc_pkg::ALU_W;

    t_state r_state, n_state;
    logic [svsc_pkg::STEP_W-1:0] r_cnt, n_cnt;
    logic r_out_valid, n_out_valid;

    logic [AW-1:0] r_a, n_a, r_b, n_b, r_c, n_c;
    logic [AW-1:0] r_nq, n_nq;
    logic [svsc_pkg::CNT_W-1:0] r_n, n_n;
    logic r_ovf, n_ovf, r_neg, n_neg;
    logic [svsc_pkg::SUM_W-1:0] r_mag, n_mag;
    logic [svsc_pkg::SQ_W-1:0] r_sq, n_sq;
    logic [svsc_pkg::NN_W-1:0] r_nn, n_nn;
    logic [svsc_pkg::VAR_W-1:0] r_var, n_var;
    logic [svsc_pkg::SD_W-1:0] r_sd, n_sd;
    logic [svsc_pkg::SD_W-1:0] r_mean_mag, n_mean_mag;
    logic [svsc_pkg::CV_W-1:0] r_cv, n_cv;
    svsc_pkg::t_out r_out, n_out;

    logic [AW-1:0] w_rem_sh, w_acc_nx, w_quot, w_root_nx, w_sdiv;
    logic          w_last_step;

    assign w_last_step = (r_cnt == '0);
    assign w_rem_sh    = {r_a[AW-2:0], r_b[AW-1]};
    assign w_acc_nx    = r_c[0] ? i_alu_rsp.res : r_a;
    assign w_quot      = {r_b[AW-2:0], i_alu_rsp.carry};
    assign w_root_nx   = i_alu_rsp.carry ? ((r_b >> 1) | r_c) : (r_b >> 1);
    assign w_sdiv      = AW'({r_sd, {svsc_pkg::SD_W{1'b0}}});

    always_comb begin
        o_alu_req.a   = r_a;
        o_alu_req.b   = r_b;
        o_alu_req.sub = 1'b0;
        case (r_state)
            ST_NUM: begin
                o_alu_req.a   = r_nq;
                o_alu_req.b   = r_a;
                o_alu_req.sub = 1'b1;
            end
            ST_DIV_VAR, ST_DIV_MEAN, ST_DIV_CV: begin
                o_alu_req.a   = w_rem_sh;
                o_alu_req.b   = r_c;
                o_alu_req.sub = 1'b1;
            end
            ST_SQRT: begin
                o_alu_req.a   = r_a;
                o_alu_req.b   = r_b | r_c;
                o_alu_req.sub = 1'b1;
            end
            default: begin
                o_alu_req.a   = r_a;
                o_alu_req.b   = r_b;
                o_alu_req.sub = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid & ~i_ready;
        n_a         = r_a;
        n_b         = r_b;
        n_c         = r_c;
        n_nq        = r_nq;
        n_n         = r_n;
        n_ovf       = r_ovf;
        n_neg       = r_neg;
        n_mag       = r_mag;
        n_sq        = r_sq;
        n_nn        = r_nn;
        n_var       = r_var;
        n_sd        = r_sd;
        n_mean_mag  = r_mean_mag;
        n_cv        = r_cv;
        n_out       = r_out;

        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_n     = i_snap.n;
                    n_ovf   = i_snap.ovf;
                    n_neg   = i_snap.sum[svsc_pkg::SUM_W-1];
                    n_mag   = i_snap.sum[svsc_pkg::SUM_W-1] ? -i_snap.sum : i_snap.sum;
                    n_sq    = i_snap.sq;
                    n_a     = '0;
                    n_b     = AW'(i_snap.n);
                    n_c     = AW'(i_snap.n);
                    n_cnt   = svsc_pkg::STEP_W'(svsc_pkg::MUL_STEPS - 1);
                    n_state = ST_MUL_NN;
                end
            end
            ST_MUL_NN, ST_MUL_NQ, ST_MUL_S2: begin
                n_a   = w_acc_nx;
                n_b   = r_b << 1;
                n_c   = r_c >> 1;
                n_cnt = r_cnt - svsc_pkg::STEP_W'(1);
                if (w_last_step) begin
                    n_a   = '0;
                    n_cnt = svsc_pkg::STEP_W'(svsc_pkg::MUL_STEPS - 1);
                    if (r_state == ST_MUL_NN) begin
                        n_nn    = w_acc_nx[svsc_pkg::NN_W-1:0];
                        n_b     = AW'(r_sq);
                        n_c     = AW'(r_n);
                        n_state = ST_MUL_NQ;
                    end else if (r_state == ST_MUL_NQ) begin
                        n_nq    = w_acc_nx;
                        n_b     = AW'(r_mag);
                        n_c     = AW'(r_mag);
                        n_state = ST_MUL_S2;
                    end else begin
                        n_a     = w_acc_nx;
                        n_state = ST_NUM;
                    end
                end
            end
            ST_NUM: begin
                // numerator n*Q - S^2, clamped at zero
                n_b     = i_alu_rsp.carry ? i_alu_rsp.res : '0;
                n_a     = '0;
                n_c     = AW'(r_nn);
                n_cnt   = svsc_pkg::STEP_W'(svsc_pkg::DIV_STEPS - 1);
                n_state = ST_DIV_VAR;
            end
            ST_DIV_VAR, ST_DIV_MEAN, ST_DIV_CV: begin
                n_a   = i_alu_rsp.carry ? i_alu_rsp.res : w_rem_sh;
                n_b   = w_quot;
                n_cnt = r_cnt - svsc_pkg::STEP_W'(1);
                if (w_last_step) begin
                    n_a = '0;
                    if (r_state == ST_DIV_VAR) begin
                        n_var   = w_quot[svsc_pkg::VAR_W-1:0];
                        n_a     = AW'(w_quot[svsc_pkg::VAR_W-1:0]);
                        n_b     = '0;
                        n_c     = svsc_pkg::SQRT_BIT0;
                        n_cnt   = svsc_pkg::STEP_W'(svsc_pkg::SQRT_STEPS - 1);
                        n_state = ST_SQRT;
                    end else if (r_state == ST_DIV_MEAN) begin
                        n_mean_mag = w_quot[svsc_pkg::SD_W-1:0];
                        if (w_quot[svsc_pkg::SD_W-1:0] == '0) begin
                            n_cv    = '0;
                            n_state = ST_DONE;
                        end else begin
                            n_b     = w_sdiv;
                            n_c     = AW'(w_quot[svsc_pkg::SD_W-1:0]);
                            n_cnt   = svsc_pkg::STEP_W'(svsc_pkg::DIV_STEPS - 1);
                            n_state = ST_DIV_CV;
                        end
                    end else begin
                        if (r_neg) begin
                            n_cv = -w_quot[svsc_pkg::CV_W-1:0];
                        end else if (w_quot[AW-1:svsc_pkg::CV_W-1] != '0) begin
                            n_cv = svsc_pkg::CV_MAX;
                        end else begin
                            n_cv = w_quot[svsc_pkg::CV_W-1:0];
                        end
                        n_state = ST_DONE;
                    end
                end
            end
            ST_SQRT: begin
                if (i_alu_rsp.carry) begin
                    n_a = i_alu_rsp.res;
                end
                n_b   = w_root_nx;
                n_c   = r_c >> 2;
                n_cnt = r_cnt - svsc_pkg::STEP_W'(1);
                if (w_last_step) begin
                    n_sd    = w_root_nx[svsc_pkg::SD_W-1:0];
                    n_a     = '0;
                    n_b     = AW'(r_mag);
                    n_c     = AW'(r_n);
                    n_cnt   = svsc_pkg::STEP_W'(svsc_pkg::DIV_STEPS - 1);
                    n_state = ST_DIV_MEAN;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out.mean         = r_neg ? -r_mean_mag : r_mean_mag;
                    n_out.variance     = r_var;
                    n_out.std_dev      = r_sd;
                    n_out.coeff_var    = r_cv;
                    n_out.cv_undefined = (r_mean_mag == '0);
                    n_out.sample_count = r_n;
                    n_out.too_many     = r_ovf;
                    n_out_valid        = 1'b1;
                    n_state            = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a        <= n_a;
        r_b        <= n_b;
        r_c        <= n_c;
        r_nq       <= n_nq;
        r_n        <= n_n;
        r_ovf      <= n_ovf;
        r_neg      <= n_neg;
        r_mag      <= n_mag;
        r_sq       <= n_sq;
        r_nn       <= n_nn;
        r_var      <= n_var;
        r_sd       <= n_sd;
        r_mean_mag <= n_mean_mag;
        r_cv       <= n_cv;
        r_out      <= n_out;
    end

    assign o_idle  = (r_state == ST_IDLE);
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

### hdl/stream_variance_stddev_cv_top.sv
// ----------------------------------------------------------------------------
// stream_variance_stddev_cv_top: population mean, variance, std dev and CV
// Samples that are not last are taken one per cycle while the sequencer is
// idle (accumulator update). A last sample starts the shared-ALU sequence,
// ready low meanwhile: 3x26 multiply steps, a numerator subtract, 16 root
// steps and 3x52 divide steps (no CV divide when the mean magnitude is zero).
// Synchronous active-low reset clears accumulators, sequencer and output valid.
// ----------------------------------------------------------------------------
module stream_variance_stddev_cv_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  svsc_pkg::t_in   i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output svsc_pkg::t_out  o_data
);

    logic               w_accept;
    svsc_pkg::t_snap    w_snap;
    svsc_pkg::t_alu_req w_alu_req;
    svsc_pkg::t_alu_rsp w_alu_rsp;

    assign w_accept = i_valid & o_ready;

    svsc_acc u_acc (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_item   (i_data),
        .o_snap   (w_snap)
    );

    svsc_alu u_alu (
        .i_req (w_alu_req),
        .o_rsp (w_alu_rsp)
    );

    svsc_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_accept & i_data.last),
        .i_snap    (w_snap),
        .o_idle    (o_ready),
        .o_alu_req (w_alu_req),
        .i_alu_rsp (w_alu_rsp),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_data    (o_data)
    );

endmodule

### hdl/svsc_chk.sv
// ----------------------------------------------------------------------------
// svsc_chk: port-level checks for the stream statistics block
// Watches the top level's ports; bound to the top level below.
// ----------------------------------------------------------------------------
module svsc_chk (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_valid,
    input logic            o_ready,
    input svsc_pkg::t_in   i_data,
    input logic            o_valid,
    input logic            i_ready,
    input svsc_pkg::t_out  o_data
);

    logic [2*svsc_pkg::SD_W-1:0] w_sd_sq;
    logic [2*svsc_pkg::SD_W+1:0] w_sd1_sq;
    logic [svsc_pkg::SD_W:0]     w_sd1;

    assign w_sd1    = {1'b0, o_data.std_dev} + 17'd1;
    assign w_sd_sq  = o_data.std_dev * o_data.std_dev;
    assign w_sd1_sq = 34'(w_sd1) * 34'(w_sd1);

    // a result waiting for its transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result changed while stalled");

    // a last sample starts the end-of-vector sequence
    a_busy_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_data.last |=> !o_ready)
        else $error("ready high right after last sample");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.sample_count != '0
                 && o_data.sample_count <= svsc_pkg::MAX_CNT)
        else $error("sample count out of range");

    a_cv_undef: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.cv_undefined |-> o_data.coeff_var == '0 && o_data.mean == '0)
        else $error("undefined CV with non-zero value or mean");

    a_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> 34'(w_sd_sq) <= 34'(o_data.variance)
                 && w_sd1_sq > 34'(o_data.variance))
        else $error("std dev is not the floor root of variance");

endmodule

bind stream_variance_stddev_cv_top svsc_chk u_svsc_chk (.*);
